FILE: src/windowed_jet_pseudocolor_fusion_defines.svh
// Assertion macros used by the checker file.
`ifndef WINDOWED_JET_PSEUDOCOLOR_FUSION_DEFINES_SVH
`define WINDOWED_JET_PSEUDOCOLOR_FUSION_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define WJP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define WJP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

FILE: src/wjp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wjp_pkg
// Types, register indexes, sequencer states and the jet colour table.
// ----------------------------------------------------------------------------
package wjp_pkg;

  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_WINDOW_HIGH   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_WINDOW_LOW    = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_PHOTO_PRESENT = 2'd2;
  localparam int unsigned CfgDataW = 16;

  localparam logic OP_STATS = 1'b0;
  localparam logic OP_MAP   = 1'b1;

  // Divider operand widths: numerator is at most 16 bits times 255.
  localparam int unsigned NumW = 24;
  localparam int unsigned DenW = 16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SMIN,
    ST_SMAX,
    ST_SCALE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic            start;
    logic [NumW-1:0] num;
    logic [DenW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [NumW-1:0] quo;
  } div_rsp_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  function automatic logic [7:0] ramp(input logic [7:0] n_in);
    logic [7:0] n;
    n = (n_in > 8'd64) ? 8'd64 : n_in;
    return (n <= 8'd32) ? 8'(n << 2) : 8'((n << 2) - 8'd1);
  endfunction

  // Jet entry for index i (0..254).
  function automatic rgb_t jet(input logic [7:0] i_in);
    rgb_t c;
    logic [7:0] i;
    i = (i_in > 8'd254) ? 8'd254 : i_in;
    if (i < 8'd32) begin
      c = '{8'd0, 8'd0, ramp(8'(i + 8'd33))};
    end else if (i < 8'd96) begin
      c = '{8'd0, ramp(8'(i - 8'd31)), 8'd255};
    end else if (i < 8'd160) begin
      c = '{ramp(8'(i - 8'd95)), 8'd255, ramp(8'(8'd159 - i))};
    end else if (i < 8'd224) begin
      c = '{8'd255, ramp(8'(8'd223 - i)), 8'd0};
    end else begin
      c = '{ramp(8'(9'd287 - {1'b0, i})), 8'd0, 8'd0};
    end
    return c;
  endfunction

endpackage

FILE: src/wjp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wjp_in_if / wjp_out_if
// Valid/ready channels for pixel beats and result beats.
// ----------------------------------------------------------------------------
interface wjp_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic        first_of_frame;
  logic [15:0] lum_pixel;
  logic [7:0]  photo_gray;
  modport source (output valid, operation, first_of_frame, lum_pixel, photo_gray,
                  input ready);
  modport sink (input valid, operation, first_of_frame, lum_pixel, photo_gray,
                output ready);
endinterface

interface wjp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] slice_level;
  logic [7:0] pseudo_red;
  logic [7:0] pseudo_green;
  logic [7:0] pseudo_blue;
  logic [7:0] pseudo_alpha;
  logic [7:0] fused_red;
  logic [7:0] fused_green;
  logic [7:0] fused_blue;
  logic       range_error;
  modport source (output valid, slice_level, pseudo_red, pseudo_green, pseudo_blue,
                  pseudo_alpha, fused_red, fused_green, fused_blue, range_error,
                  input ready);
  modport sink (input valid, slice_level, pseudo_red, pseudo_green, pseudo_blue,
                pseudo_alpha, fused_red, fused_green, fused_blue, range_error,
                output ready);
endinterface

FILE: src/wjp_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wjp_divider
// Restoring radix-2 divider, one quotient bit per cycle, truncating.
// ----------------------------------------------------------------------------
module wjp_divider (
  input  logic              clk,
  input  logic              rst_n,
  input  wjp_pkg::div_req_t req,
  output wjp_pkg::div_rsp_t rsp
);

  localparam int unsigned NW = wjp_pkg::NumW;
  localparam int unsigned DW = wjp_pkg::DenW;
  localparam int unsigned CW = $clog2(NW + 1);

  logic [NW-1:0] quo_r, quo_nxt;
  logic [DW:0]   rem_r, rem_nxt;
  logic [DW-1:0] den_r, den_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [DW:0]   trial;

  // One shift-and-subtract step per cycle.
  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r[DW-1:0], quo_r[NW-1]};
    if (req.start) begin
      quo_nxt  = req.num;
      rem_nxt  = '0;
      den_nxt  = req.den;
      cnt_nxt  = CW'(NW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        quo_nxt = {quo_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

endmodule

FILE: src/windowed_jet_pseudocolor_fusion.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// windowed_jet_pseudocolor_fusion
// Window/level slicing of luminescence pixels, jet lookup and photo fusion.
// ----------------------------------------------------------------------------
// Channel | Direction | Content
// in      | sink      | operation, first_of_frame, lum_pixel, photo_gray
// out     | source    | slice, pseudo RGBA, fused RGB, range_error
// cfg     | write     | window_high, window_low, photo_present
//
// A statistics beat needs no division. A mapping beat takes up to three
// divisions on one shared radix-2 divider of 24 steps each; window errors
// and flat extrema skip divisions. The result sits in an output register;
// the next pixel is taken once it has gone. Reset is synchronous and clears
// the extrema to their reset values.
// ----------------------------------------------------------------------------
module windowed_jet_pseudocolor_fusion #(
  parameter int unsigned PIXEL_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  wjp_in_if.sink                          in_ch,
  wjp_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [wjp_pkg::CfgIdxW-1:0]     cfg_index,
  input  logic [wjp_pkg::CfgDataW-1:0]    cfg_data
);

  localparam int unsigned NW = wjp_pkg::NumW;
  localparam int unsigned DW = wjp_pkg::DenW;
  localparam logic [15:0] PixMask = 16'((32'd1 << PIXEL_BITS) - 32'd1);

  wjp_pkg::state_t state_r, state_nxt;

  logic [15:0] win_hi_r, win_lo_r;
  logic        photo_r;
  logic [15:0] fmin_r, fmax_r;

  logic        op_r, first_r;
  logic [15:0] v_r;
  logic [7:0]  gray_r;
  logic [15:0] hi_r, lo_r, cmin_r, cmax_r;
  logic [7:0]  smin_r, smax_r;
  logic        busy_r, busy_nxt;
  logic        oval_r;
  logic        div_pend_r;

  logic [7:0]  slice_r;
  logic        err_r;

  wjp_pkg::div_req_t div_req;
  wjp_pkg::div_rsp_t div_rsp;

  wjp_divider u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));

  logic accept;
  assign in_ch.ready = !busy_r && !oval_r;
  assign accept      = in_ch.valid && in_ch.ready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_hi_r <= '0;
      win_lo_r <= '0;
      photo_r  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        wjp_pkg::CFG_WINDOW_HIGH:   win_hi_r <= cfg_data;
        wjp_pkg::CFG_WINDOW_LOW:    win_lo_r <= cfg_data;
        wjp_pkg::CFG_PHOTO_PRESENT: photo_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Window selection and clamped extrema, from registered inputs.
  logic [15:0] hi_c, lo_c, cmin_c, cmax_c;
  always_comb begin
    if (win_hi_r == '0 && win_lo_r == '0) begin
      hi_c = fmax_r;
      lo_c = fmin_r;
    end else begin
      hi_c = win_hi_r & PixMask;
      lo_c = win_lo_r & PixMask;
    end
    cmin_c = (fmin_r < lo_c) ? lo_c : ((fmin_r > hi_c) ? hi_c : fmin_r);
    cmax_c = (fmax_r < lo_c) ? lo_c : ((fmax_r > hi_c) ? hi_c : fmax_r);
  end

  // Quotient patched to smin/smax floors.
  logic [7:0] q8, smin_fix, smax_fix;
  assign q8       = div_rsp.quo[7:0];
  assign smin_fix = (q8 == 8'd0) ? 8'd1 : q8;
  assign smax_fix = (q8 < 8'd2) ? 8'd2 : q8;

  logic [15:0] vc;
  logic [15:0] vw;
  always_comb begin
    vw = (v_r < lo_r) ? lo_r : ((v_r > hi_r) ? hi_r : v_r);
    vc = (vw < cmin_r) ? cmin_r : ((vw > cmax_r) ? cmax_r : vw);
  end

  logic flat;
  assign flat = (cmin_r >= cmax_r) || (smax_fix < smin_r);

  logic [7:0] s_forced;
  function automatic logic [7:0] force_s(input logic [7:0] s, input logic [15:0] v,
                                         input logic [15:0] lo, input logic [15:0] hi);
    logic [7:0] t;
    t = s;
    if (v < lo) t = 8'd0;
    if (v > hi) t = 8'd255;
    return t;
  endfunction

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      wjp_pkg::ST_IDLE:  if (busy_r) begin
        if (op_r == wjp_pkg::OP_STATS) state_nxt = wjp_pkg::ST_IDLE;
        else if (hi_r <= lo_r)          state_nxt = wjp_pkg::ST_DONE;
        else                            state_nxt = wjp_pkg::ST_SMIN;
      end
      wjp_pkg::ST_SMIN:  if (div_rsp.done && !div_pend_r) state_nxt = wjp_pkg::ST_SMAX;
      wjp_pkg::ST_SMAX:  if (div_rsp.done && !div_pend_r) begin
        state_nxt = flat ? wjp_pkg::ST_DONE : wjp_pkg::ST_SCALE;
      end
      wjp_pkg::ST_SCALE: if (div_rsp.done && !div_pend_r) state_nxt = wjp_pkg::ST_DONE;
      wjp_pkg::ST_DONE:  state_nxt = wjp_pkg::ST_IDLE;
      default:           state_nxt = wjp_pkg::ST_IDLE;
    endcase
  end

  // Divider requests and busy flag.
  always_comb begin
    div_req.start = 1'b0;
    div_req.num   = '0;
    div_req.den   = hi_r - lo_r;
    busy_nxt      = busy_r;
    if (accept) busy_nxt = 1'b1;
    case (state_r)
      wjp_pkg::ST_IDLE: begin
        if (busy_r && op_r == wjp_pkg::OP_MAP && hi_r > lo_r) begin
          div_req.start = 1'b1;
          div_req.num   = NW'((cmin_r - lo_r) * 24'd255);
        end else if (busy_r && op_r == wjp_pkg::OP_STATS) begin
          busy_nxt = 1'b0;
        end
      end
      wjp_pkg::ST_SMIN: if (div_rsp.done && !div_pend_r) begin
        div_req.start = 1'b1;
        div_req.num   = NW'((cmax_r - lo_r) * 24'd255);
      end
      wjp_pkg::ST_SMAX: if (div_rsp.done && !div_pend_r && !flat) begin
        div_req.start = 1'b1;
        div_req.num   = NW'(24'(vc - cmin_r) * 24'(smax_fix - smin_r));
        div_req.den   = cmax_r - cmin_r;
      end
      wjp_pkg::ST_DONE: busy_nxt = 1'b0;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= wjp_pkg::ST_IDLE;
      busy_r     <= 1'b0;
      oval_r     <= 1'b0;
      div_pend_r <= 1'b0;
      fmin_r     <= PixMask;
      fmax_r     <= '0;
    end else begin
      state_r    <= state_nxt;
      busy_r     <= busy_nxt;
      div_pend_r <= div_req.start;
      if (state_r == wjp_pkg::ST_DONE) oval_r <= 1'b1;
      else if (out_ch.ready) oval_r <= 1'b0;
      // Statistics update in the cycle after the beat is taken.
      if (state_r == wjp_pkg::ST_IDLE && busy_r && op_r == wjp_pkg::OP_STATS) begin
        if (first_r) begin
          fmin_r <= v_r;
          fmax_r <= v_r;
        end else begin
          if (v_r < fmin_r) fmin_r <= v_r;
          if (v_r > fmax_r) fmax_r <= v_r;
        end
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r    <= in_ch.operation;
      first_r <= in_ch.first_of_frame;
      v_r     <= in_ch.lum_pixel & PixMask;
      gray_r  <= in_ch.photo_gray;
      hi_r    <= hi_c;
      lo_r    <= lo_c;
      cmin_r  <= cmin_c;
      cmax_r  <= cmax_c;
    end
    if (state_r == wjp_pkg::ST_SMIN && div_rsp.done && !div_pend_r) smin_r <= smin_fix;
    if (state_r == wjp_pkg::ST_SMAX && div_rsp.done && !div_pend_r) begin
      smax_r  <= smax_fix;
      slice_r <= force_s(smin_r, v_r, lo_r, hi_r);
    end
    if (state_r == wjp_pkg::ST_SCALE && div_rsp.done && !div_pend_r) begin
      slice_r <= force_s(8'(smin_r + q8), v_r, lo_r, hi_r);
    end
    if (state_r == wjp_pkg::ST_IDLE && busy_r && hi_r <= lo_r) begin
      slice_r <= (v_r > hi_r) ? 8'd255 : 8'd0;
    end
    if (state_r == wjp_pkg::ST_IDLE && busy_r) err_r <= (hi_r <= lo_r);
  end

  // Colour lookup on the final slice level.
  wjp_pkg::rgb_t c_s;
  assign c_s = wjp_pkg::jet((slice_r != 8'd0) ? 8'(slice_r - 8'd1) : 8'd0);
  assign s_forced = slice_r;

  logic fuse;
  assign fuse = (s_forced == 8'd0) && photo_r;

  // Output register.
  always_ff @(posedge clk) begin
    if (state_r == wjp_pkg::ST_DONE) begin
      out_ch.slice_level  <= s_forced;
      out_ch.pseudo_red   <= c_s.r;
      out_ch.pseudo_green <= c_s.g;
      out_ch.pseudo_blue  <= c_s.b;
      out_ch.pseudo_alpha <= (s_forced != 8'd0) ? 8'd255 : 8'd0;
      out_ch.fused_red    <= fuse ? gray_r : c_s.r;
      out_ch.fused_green  <= fuse ? gray_r : c_s.g;
      out_ch.fused_blue   <= fuse ? gray_r : c_s.b;
      out_ch.range_error  <= err_r;
    end
  end
  assign out_ch.valid = oval_r;

  logic unused;
  assign unused = ^smax_r ^ ^div_rsp.quo[NW-1:8] ^ DW[0];

endmodule

FILE: src/wjp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wjp_checker
// Port-level checks on the pseudocolour block, bound to the top level.
// ----------------------------------------------------------------------------
`include "windowed_jet_pseudocolor_fusion_defines.svh"
module wjp_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] slice_level,
  input logic [7:0] pseudo_alpha,
  input logic       range_error
);
  // A waiting result holds its beat.
  `WJP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  // No pixel is taken while a result waits.
  `WJP_ASSERT_IMP(a_no_take, clk, rst_n, out_valid, !in_ready)
  // Alpha follows the slice level.
  `WJP_ASSERT_IMP(a_alpha, clk, rst_n, out_valid,
    (pseudo_alpha == 8'd255) == (slice_level != 8'd0))
  // A window error only ever yields the two forced levels.
  `WJP_ASSERT_IMP(a_err_lvl, clk, rst_n, out_valid && range_error,
    slice_level == 8'd0 || slice_level == 8'd255)
endmodule

bind windowed_jet_pseudocolor_fusion wjp_checker u_wjp_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .slice_level(out_ch.slice_level), .pseudo_alpha(out_ch.pseudo_alpha),
  .range_error(out_ch.range_error));

FILE: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench for windowed_jet_pseudocolor_fusion: statistics and mapping
// beats are sent with random idling on both channels. A scoreboard predicts
// every mapping result from its own copy of the extrema and registers.
// ----------------------------------------------------------------------------
module tb;

  typedef struct packed {
    logic [7:0] slice;
    logic [7:0] pr;
    logic [7:0] pg;
    logic [7:0] pb;
    logic [7:0] pa;
    logic [7:0] fr;
    logic [7:0] fg;
    logic [7:0] fb;
    logic       err;
  } pix_result_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [wjp_pkg::CfgIdxW-1:0] cfg_index;
  logic [wjp_pkg::CfgDataW-1:0] cfg_data;

  wjp_in_if in_ch ();
  wjp_out_if out_ch ();

  windowed_jet_pseudocolor_fusion i_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Predictor state.
  logic [15:0] win_hi, win_lo, fmin, fmax;
  logic        photo_on;
  pix_result_t expected_pixels[$];

  int errors = 0;
  int n_stats = 0, n_maps = 0, n_seen = 0;
  int send_idle_pct = 0, recv_idle_pct = 0;
  int quiet_cycles = 0;
  int unsigned sent_in_beats = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic logic [7:0] jet_ramp(input int n);
    if (n > 64) n = 64;
    return (n <= 32) ? 8'(4 * n) : 8'(4 * n - 1);
  endfunction

  function automatic void jet_colour(input int i, output logic [7:0] r, g, b);
    if (i > 254) i = 254;
    if (i < 32) begin
      r = 8'd0; g = 8'd0; b = jet_ramp(i + 33);
    end else if (i < 96) begin
      r = 8'd0; g = jet_ramp(i - 31); b = 8'd255;
    end else if (i < 160) begin
      r = jet_ramp(i - 95); g = 8'd255; b = jet_ramp(159 - i);
    end else if (i < 224) begin
      r = 8'd255; g = jet_ramp(223 - i); b = 8'd0;
    end else begin
      r = jet_ramp(287 - i); g = 8'd0; b = 8'd0;
    end
  endfunction

  function automatic longint unsigned clamp_to(input longint unsigned v, lo, hi);
    if (v < lo) v = lo;
    if (v > hi) v = hi;
    return v;
  endfunction

  // Works out the slice level and colours of one mapping pixel.
  function automatic pix_result_t map_pixel(input logic [15:0] pix, input logic [7:0] gray);
    pix_result_t res;
    longint unsigned hi, lo, v, cmin, cmax, smin, smax, s, vc;
    v = pix;
    if (win_hi == 0 && win_lo == 0) begin
      hi = fmax; lo = fmin;
    end else begin
      hi = win_hi; lo = win_lo;
    end
    if (hi <= lo) begin
      res.err = 1'b1;
      s = (v > hi) ? 255 : 0;
    end else begin
      res.err = 1'b0;
      cmin = clamp_to(fmin, lo, hi);
      cmax = clamp_to(fmax, lo, hi);
      smin = (cmin - lo) * 255 / (hi - lo);
      smax = (cmax - lo) * 255 / (hi - lo);
      if (smin == 0) smin = 1;
      if (smax < 2) smax = 2;
      if (cmin >= cmax || smax < smin) begin
        s = smin;
      end else begin
        vc = clamp_to(clamp_to(v, lo, hi), cmin, cmax);
        s = smin + (vc - cmin) * (smax - smin) / (cmax - cmin);
      end
      if (v < lo) s = 0;
      if (v > hi) s = 255;
    end
    res.slice = 8'(s);
    jet_colour((res.slice > 0) ? res.slice - 1 : 0, res.pr, res.pg, res.pb);
    res.pa = (res.slice > 0) ? 8'd255 : 8'd0;
    if (res.slice == 0 && photo_on) begin
      res.fr = gray; res.fg = gray; res.fb = gray;
    end else begin
      res.fr = res.pr; res.fg = res.pg; res.fb = res.pb;
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  // Sends one pixel beat and updates the predictor when it is accepted.
  task automatic send_pixel(input logic op, input logic first, input logic [15:0] pix,
                            input logic [7:0] gray);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    in_ch.valid = 1'b1;
    in_ch.operation = op;
    in_ch.first_of_frame = first;
    in_ch.lum_pixel = pix;
    in_ch.photo_gray = gray;
    do @(posedge clk); while (!in_ch.ready);
    if (op == wjp_pkg::OP_STATS) begin
      n_stats++;
      if (first) begin
        fmin = pix; fmax = pix;
      end else begin
        if (pix < fmin) fmin = pix;
        if (pix > fmax) fmax = pix;
      end
    end else begin
      n_maps++;
      expected_pixels.push_back(map_pixel(pix, gray));
    end
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  task automatic drain_results();
    while (expected_pixels.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  task automatic write_reg(input logic [wjp_pkg::CfgIdxW-1:0] idx, input logic [15:0] val);
    cfg_we = 1'b1; cfg_index = idx; cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      wjp_pkg::CFG_WINDOW_HIGH: win_hi = val;
      wjp_pkg::CFG_WINDOW_LOW: win_lo = val;
      default: photo_on = val[0];
    endcase
  endtask

  task automatic set_window(input logic [15:0] hi, lo, input logic photo);
    drain_results();
    write_reg(wjp_pkg::CFG_WINDOW_HIGH, hi);
    write_reg(wjp_pkg::CFG_WINDOW_LOW, lo);
    write_reg(wjp_pkg::CFG_PHOTO_PRESENT, 16'(photo));
  endtask

  // Receiver: random back-pressure, compares each result beat.
  always @(negedge clk) out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);

  always @(posedge clk) begin
    pix_result_t got, want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.slice_level, out_ch.pseudo_red, out_ch.pseudo_green, out_ch.pseudo_blue,
              out_ch.pseudo_alpha, out_ch.fused_red, out_ch.fused_green, out_ch.fused_blue,
              out_ch.range_error};
      n_seen++;
      if (expected_pixels.size() == 0) begin
        report_mismatch("unexpected result beat", got.slice, -1);
      end else begin
        want = expected_pixels.pop_front();
        if (got.slice !== want.slice) report_mismatch("slice_level", got.slice, want.slice);
        if (got.pr !== want.pr) report_mismatch("pseudo_red", got.pr, want.pr);
        if (got.pg !== want.pg) report_mismatch("pseudo_green", got.pg, want.pg);
        if (got.pb !== want.pb) report_mismatch("pseudo_blue", got.pb, want.pb);
        if (got.pa !== want.pa) report_mismatch("pseudo_alpha", got.pa, want.pa);
        if (got.fr !== want.fr) report_mismatch("fused_red", got.fr, want.fr);
        if (got.fg !== want.fg) report_mismatch("fused_green", got.fg, want.fg);
        if (got.fb !== want.fb) report_mismatch("fused_blue", got.fb, want.fb);
        if (got.err !== want.err) report_mismatch("range_error", got.err, want.err);
      end
    end
  end

  // Watchdog on cycles without any accepted beat.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles > 20000) begin
      $display("Watchdog expired");
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Pixels before and after reset extrema, with stale extrema on mapping.
  task automatic test_directed();
    set_window(0, 0, 1);
    send_pixel(wjp_pkg::OP_MAP, 1, 16'd100, 8'd77);      // reset extrema: window error
    set_window(16'd1000, 16'd10, 1);
    send_pixel(wjp_pkg::OP_MAP, 0, 16'd500, 8'd1);       // stale extrema
    send_pixel(wjp_pkg::OP_STATS, 1, 16'd0, 8'hFF);
    send_pixel(wjp_pkg::OP_STATS, 0, 16'hFFFF, 8'h00);
    send_pixel(wjp_pkg::OP_STATS, 0, 16'd300, 8'h00);
    send_pixel(wjp_pkg::OP_MAP, 0, 16'd0, 8'hAA);        // below window
    send_pixel(wjp_pkg::OP_MAP, 1, 16'hFFFF, 8'h55);     // above window
    send_pixel(wjp_pkg::OP_MAP, 0, 16'd10, 8'd200);
    send_pixel(wjp_pkg::OP_MAP, 0, 16'd1000, 8'd200);
    send_pixel(wjp_pkg::OP_MAP, 0, 16'd505, 8'd200);
    set_window(0, 0, 0);                                 // automatic window
    send_pixel(wjp_pkg::OP_MAP, 0, 16'd0, 8'd9);
    send_pixel(wjp_pkg::OP_MAP, 0, 16'hFFFF, 8'd9);
    send_pixel(wjp_pkg::OP_MAP, 0, 16'h8000, 8'd9);
    send_pixel(wjp_pkg::OP_STATS, 1, 16'd40, 8'd0);      // equal extrema
    send_pixel(wjp_pkg::OP_MAP, 0, 16'd40, 8'd9);
    set_window(16'hFFFF, 16'hFFFF, 1);                   // high not above low
    send_pixel(wjp_pkg::OP_MAP, 0, 16'hFFFF, 8'd3);
    send_pixel(wjp_pkg::OP_MAP, 0, 16'd0, 8'd3);
    set_window(16'd50, 16'd40, 1);                       // equal extrema inside window
    send_pixel(wjp_pkg::OP_STATS, 1, 16'd45, 8'd0);
    send_pixel(wjp_pkg::OP_MAP, 0, 16'd41, 8'd3);
    send_pixel(wjp_pkg::OP_MAP, 0, 16'd49, 8'd3);
    // Sender holds off until every result is back.
    while (expected_pixels.size() != 0) @(negedge clk);
  endtask

  // Frames of statistics beats then mapping beats, with stray noise beats.
  task automatic test_random_frames(input int n_pixels);
    logic [15:0] base, spread, hi, lo;
    int k, len;
    k = 0;
    while (k < n_pixels) begin
      case ($urandom_range(5))
        0: set_window(0, 0, 1'($urandom));
        1: set_window(16'hFFFF, 0, 1'($urandom));
        2: set_window(16'($urandom), 16'($urandom), 1'($urandom));
        default: begin
          lo = 16'($urandom);
          hi = lo + 16'($urandom_range(600));
          set_window(hi, lo, 1'($urandom));
        end
      endcase
      base = ($urandom_range(3) == 0) ? 16'($urandom) : (win_lo + 16'($urandom_range(200)));
      spread = 16'($urandom_range(($urandom_range(3) == 0) ? 65535 : 800));
      len = $urandom_range(2, 12);
      for (int j = 0; j < len; j++) begin
        send_pixel(wjp_pkg::OP_STATS, j == 0, base + 16'($urandom_range(spread)),
                   8'($urandom));
        k++;
      end
      len = $urandom_range(3, 20);
      for (int j = 0; j < len; j++) begin
        if ($urandom_range(9) == 0) begin
          send_pixel(1'($urandom), 1'($urandom), 16'($urandom), 8'($urandom));
        end else begin
          send_pixel(wjp_pkg::OP_MAP, 1'($urandom),
                     base + 16'($urandom_range(spread + 100)) - 16'd50, 8'($urandom));
        end
        k++;
      end
    end
  endtask

  initial begin
    rst_n = 0;
    cfg_we = 0; cfg_index = '0; cfg_data = '0;
    in_ch.valid = 0; in_ch.operation = 0; in_ch.first_of_frame = 0;
    in_ch.lum_pixel = 0; in_ch.photo_gray = 0;
    out_ch.ready = 0;
    win_hi = 0; win_lo = 0; photo_on = 0; fmin = 16'hFFFF; fmax = 0;
    repeat (5) @(negedge clk);
    rst_n = 1;
    @(negedge clk);

    send_idle_pct = 7; recv_idle_pct = 62;
    test_directed();
    test_random_frames(480);
    send_idle_pct = 62; recv_idle_pct = 7;
    test_random_frames(480);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random_frames(480);
    drain_results();

    $display("Covered %0d statistics and %0d mapping beats, %0d results checked,",
             n_stats, n_maps, n_seen);
    $display("across fixed, automatic and inverted windows with and without fusion.");
    if (errors == 0 && expected_pixels.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

FILE: windowed_jet_pseudocolor_fusion.f
+incdir+src
src/wjp_pkg.sv
src/wjp_if.sv
src/wjp_divider.sv
src/windowed_jet_pseudocolor_fusion.sv
src/wjp_checker.sv
verif/tb.sv
